[rtl/core/tmcw_pkg.sv]
// tmcw_pkg: shared types and constants of the text-mode console writer
// depends on nothing; used by the front, queue, back, top level and bench
package tmcw_pkg;

  // command codes on the input channel
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SET   = 2'd3
  } cmd_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_CLEAR,
    OP_SET
  } op_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN
  } state_t;

  localparam logic [7:0]  LINE_FEED    = 8'd10;
  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [15:0] BLANK_BOTTOM = 16'h0700;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/core/tmcw_if.sv]
// tmcw_cmd_if / tmcw_rsp_if: valid/ready channels of the console writer
// depends on nothing
interface tmcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [6:0] column;
  logic [4:0] row;

  modport source(output valid, command, char_code, column, row, input ready);
  modport sink(input valid, command, char_code, column, row, output ready);
endinterface

interface tmcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_entry;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;

  modport source(output valid, cell_entry, cursor_column, cursor_row, input ready);
  modport sink(input valid, cell_entry, cursor_column, cursor_row, output ready);
endinterface

[rtl/core/tmcw_front.sv]
// tmcw_front: accepts command items, saturates positions and classifies them
// depends on tmcw_pkg and tmcw_cmd_if; feeds tmcw_queue
module tmcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int COL_W   = 7,
  parameter int ROW_W   = 5,
  parameter int ADDR_W  = 11,
  parameter int ITEM_W  = 34
) (
  tmcw_cmd_if.sink          cmd,
  input  logic              init_busy,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [ITEM_W-1:0] push_data
);

  typedef struct packed {
    tmcw_pkg::op_t     op;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } item_t;

  item_t            item;
  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;

  // no items while the screen is being cleared after reset
  assign cmd.ready  = push_ready && !init_busy;
  assign push_valid = cmd.valid && !init_busy;

  // saturate requested position to the screen
  always_comb begin
    if (32'(cmd.column) > COLUMNS - 1) col_sat = COL_W'(COLUMNS - 1);
    else col_sat = COL_W'(cmd.column);
    if (32'(cmd.row) > ROWS - 1) row_sat = ROW_W'(ROWS - 1);
    else row_sat = ROW_W'(cmd.row);
  end

  // classify the command
  always_comb begin
    item.ch   = cmd.char_code;
    item.col  = col_sat;
    item.row  = row_sat;
    item.addr = ADDR_W'(row_sat) * ADDR_W'(COLUMNS) + ADDR_W'(col_sat);
    case (tmcw_pkg::cmd_t'(cmd.command))
      tmcw_pkg::CMD_PUT: begin
        if (cmd.char_code == tmcw_pkg::LINE_FEED) item.op = tmcw_pkg::OP_NEWLINE;
        else item.op = tmcw_pkg::OP_PUT;
      end
      tmcw_pkg::CMD_READ:  item.op = tmcw_pkg::OP_READ;
      tmcw_pkg::CMD_CLEAR: item.op = tmcw_pkg::OP_CLEAR;
      default:             item.op = tmcw_pkg::OP_SET;
    endcase
  end

  assign push_data = ITEM_W'(item);

endmodule

[rtl/core/tmcw_queue.sv]
// tmcw_queue: short fifo between the front and the back of the console writer
// depends on tmcw_pkg for its depth
module tmcw_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = tmcw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

[rtl/core/tmcw_back.sv]
// tmcw_back: executes classified items on the screen memory and the cursor
// depends on tmcw_pkg and tmcw_rsp_if; fed by tmcw_queue
module tmcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int COL_W   = 7,
  parameter int ROW_W   = 5,
  parameter int ADDR_W  = 11,
  parameter int ITEM_W  = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        attr,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [ITEM_W-1:0] q_data,
  output logic              init_busy,
  tmcw_rsp_if.source        rsp
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_CELL  = CELL_COUNT - 1;
  localparam int COPY_CELLS = CELL_COUNT - COLUMNS;

  typedef struct packed {
    tmcw_pkg::op_t     op;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } item_t;

  item_t               q_item;
  tmcw_pkg::state_t    state;
  tmcw_pkg::state_t    state_next;
  logic [ADDR_W-1:0]   ptr;
  logic [ADDR_W-1:0]   ptr_next;
  logic [COL_W-1:0]    cur_col;
  logic [COL_W-1:0]    cur_col_next;
  logic [ROW_W-1:0]    cur_row;
  logic [ROW_W-1:0]    cur_row_next;
  logic                stage_valid;
  logic [ADDR_W-1:0]   stage_addr;
  logic                stage_blank;
  logic                out_valid;
  logic [15:0]         out_cell;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [15:0]         cells [CELL_COUNT];
  logic [15:0]         rdata;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [15:0]         wdata;
  logic                re;
  logic [ADDR_W-1:0]   raddr;
  logic                emit;
  logic [15:0]         emit_cell;
  logic                pop;
  logic                ptr_last;
  logic                ptr_blank;
  logic                col_last;
  logic                row_last;
  logic                line_end;
  logic [ADDR_W-1:0]   cur_addr;

  assign q_item    = item_t'(q_data);
  assign ptr_last  = ptr == ADDR_W'(LAST_CELL);
  assign ptr_blank = 32'(ptr) >= COPY_CELLS;
  assign col_last  = cur_col == COL_W'(COLUMNS - 1);
  assign row_last  = cur_row == ROW_W'(ROWS - 1);
  assign line_end  = (q_item.op == tmcw_pkg::OP_NEWLINE) ||
                     (q_item.op == tmcw_pkg::OP_PUT && col_last);
  assign cur_addr  = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign pop       = (state == tmcw_pkg::ST_IDLE) && q_valid && (!out_valid || rsp.ready);
  assign init_busy = state == tmcw_pkg::ST_INIT;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tmcw_pkg::ST_INIT: if (ptr_last) state_next = tmcw_pkg::ST_IDLE;
      tmcw_pkg::ST_IDLE: begin
        if (pop) begin
          case (q_item.op)
            tmcw_pkg::OP_READ:  state_next = tmcw_pkg::ST_READ;
            tmcw_pkg::OP_CLEAR: state_next = tmcw_pkg::ST_CLEAR;
            default: if (line_end && row_last) state_next = tmcw_pkg::ST_SCROLL;
          endcase
        end
      end
      tmcw_pkg::ST_READ:   state_next = tmcw_pkg::ST_IDLE;
      tmcw_pkg::ST_CLEAR:  if (ptr_last) state_next = tmcw_pkg::ST_IDLE;
      tmcw_pkg::ST_SCROLL: if (ptr_last) state_next = tmcw_pkg::ST_DRAIN;
      tmcw_pkg::ST_DRAIN:  state_next = tmcw_pkg::ST_IDLE;
      default:             state_next = tmcw_pkg::ST_IDLE;
    endcase
  end

  // memory strobes, queue pop and result load
  always_comb begin
    we        = 1'b0;
    waddr     = ptr;
    wdata     = tmcw_pkg::RESET_CELL;
    re        = 1'b0;
    raddr     = q_item.addr;
    emit      = 1'b0;
    emit_cell = '0;
    q_ready   = 1'b0;
    case (state)
      tmcw_pkg::ST_INIT: we = 1'b1;
      tmcw_pkg::ST_IDLE: begin
        q_ready = pop;
        if (pop) begin
          case (q_item.op)
            tmcw_pkg::OP_PUT: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {attr, q_item.ch};
              emit  = !(col_last && row_last);
            end
            tmcw_pkg::OP_NEWLINE: emit = !row_last;
            tmcw_pkg::OP_READ:    re = 1'b1;
            tmcw_pkg::OP_SET:     emit = 1'b1;
            default: ;
          endcase
        end
      end
      tmcw_pkg::ST_READ: begin
        emit      = 1'b1;
        emit_cell = rdata;
      end
      tmcw_pkg::ST_CLEAR: begin
        we    = 1'b1;
        wdata = {attr, tmcw_pkg::SPACE_CHAR};
        emit  = ptr_last;
      end
      tmcw_pkg::ST_SCROLL: begin
        re    = !ptr_blank;
        raddr = ptr + ADDR_W'(COLUMNS);
        we    = stage_valid;
        waddr = stage_addr;
        wdata = stage_blank ? tmcw_pkg::BLANK_BOTTOM : rdata;
      end
      tmcw_pkg::ST_DRAIN: begin
        we    = stage_valid;
        waddr = stage_addr;
        wdata = stage_blank ? tmcw_pkg::BLANK_BOTTOM : rdata;
        emit  = 1'b1;
      end
      default: ;
    endcase
  end

  // cursor update and sweep pointer
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (pop) begin
      case (q_item.op)
        tmcw_pkg::OP_PUT, tmcw_pkg::OP_NEWLINE: begin
          if (line_end) begin
            cur_col_next = '0;
            if (!row_last) cur_row_next = cur_row + 1'b1;
          end else begin
            cur_col_next = cur_col + 1'b1;
          end
        end
        tmcw_pkg::OP_SET: begin
          cur_col_next = q_item.col;
          cur_row_next = q_item.row;
        end
        tmcw_pkg::OP_CLEAR: begin
          cur_col_next = '0;
          cur_row_next = '0;
        end
        default: ;
      endcase
    end
    case (state)
      tmcw_pkg::ST_INIT, tmcw_pkg::ST_CLEAR, tmcw_pkg::ST_SCROLL:
        ptr_next = ptr_last ? '0 : ptr + 1'b1;
      default: ptr_next = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tmcw_pkg::ST_INIT;
      ptr         <= '0;
      cur_col     <= '0;
      cur_row     <= '0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      ptr         <= ptr_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      stage_valid <= state == tmcw_pkg::ST_SCROLL;
      if (emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // scroll write stage and result payload
  always_ff @(posedge clk) begin
    stage_addr  <= ptr;
    stage_blank <= ptr_blank;
    if (emit) begin
      out_cell <= emit_cell;
      out_col  <= cur_col_next;
      out_row  <= cur_row_next;
    end
  end

  // screen memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) cells[waddr] <= wdata;
    if (re) rdata <= cells[raddr];
  end

  assign rsp.valid         = out_valid;
  assign rsp.cell_entry    = out_cell;
  assign rsp.cursor_column = 7'(out_col);
  assign rsp.cursor_row    = 5'(out_row);

endmodule

[rtl/core/text_mode_console_writer_top.sv]
// text_mode_console_writer_top: character-cell console with apb attribute register
// depends on tmcw_pkg, tmcw_if, tmcw_front, tmcw_queue and tmcw_back
//
// Character-cell text console of COLUMNS x ROWS 16-bit cells (character low byte,
// attribute high byte) with a cursor; every command item gives one result item with
// the cell read (read command only, else zero) and the cursor after the command.
// Items pass a classifying front end and a four-entry queue into the back end. In the
// back end put, line feed and set cursor are handled when the item is popped, read
// goes through the registered screen memory read, clear writes one cell per cycle
// after the pop, and a put or line feed that passes the bottom row scrolls the screen,
// one cell copied per cycle through the single read and write port of the screen
// memory, with a drain state to write the last cell. After reset a clearing pass over
// all COLUMNS*ROWS cells fills the screen with light grey spaces; cmd.ready stays low
// until it ends, while the attribute register (offset 0) can be written at any time.
module text_mode_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  tmcw_cmd_if.sink    cmd,
  tmcw_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(COLUMNS * ROWS);
  localparam int ITEM_W = $bits(tmcw_pkg::op_t) + 8 + COL_W + ROW_W + ADDR_W;
  localparam logic REG_TEXT_ATTR = 1'b0;

  logic [7:0]        attr;
  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_data;
  logic              init_busy;

  // attribute register on the apb port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'b0, attr} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tmcw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR) begin
      attr <= pwdata[7:0];
    end
  end

  // front end
  tmcw_front #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .COL_W(COL_W), .ROW_W(ROW_W),
    .ADDR_W(ADDR_W), .ITEM_W(ITEM_W)
  ) u_front (
    .cmd        (cmd),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue between front and back
  tmcw_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back end
  tmcw_back #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .COL_W(COL_W), .ROW_W(ROW_W),
    .ADDR_W(ADDR_W), .ITEM_W(ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // the back end only pops a queue that holds an item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_ready |-> q_valid)
    else $error("item popped from empty queue");

  // an item leaves the queue only when the result slot is free or being freed
  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (!rsp.valid || rsp.ready))
    else $error("item popped while result slot is held");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.cursor_column) <= COLUMNS - 1 && 32'(rsp.cursor_row) <= ROWS - 1))
    else $error("cursor outside the screen");
`endif

endmodule

[verif/tb_text_mode_console_writer_top.sv]
// tb_text_mode_console_writer_top: self-checking bench for the text console writer
// depends on tmcw_pkg, tmcw_if and text_mode_console_writer_top; keeps its own screen copy
// and checks every result item against its expectation, under random idling and a long output hold-off
module tb_text_mode_console_writer_top;

  localparam int SCREEN_COLS     = 80;
  localparam int SCREEN_ROWS     = 25;
  localparam int CELL_TOTAL      = SCREEN_COLS * SCREEN_ROWS;
  localparam int LIMIT_CYCLES    = 1_500_000;
  localparam int SLOW_BUDGET     = 180;
  localparam int PHASE_ITEMS     = 222;
  localparam int PHASE_COUNT     = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 100;
  localparam logic [2:0] ATTR_ADDR = 3'd0;

  typedef struct packed {
    tmcw_pkg::cmd_t command;
    logic [7:0]     char_code;
    logic [6:0]     column;
    logic [4:0]     row;
  } console_cmd_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } console_rsp_t;

  typedef struct {
    console_cmd_t item;
    bit           typed;
    console_rsp_t answer;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tmcw_cmd_if cmd_ch();
  tmcw_rsp_if rsp_ch();

  text_mode_console_writer_top uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // screen copy, cursor and attribute as the block should hold them
  logic [15:0] screen_copy [0:CELL_TOTAL-1];
  logic [6:0]  cursor_col_copy;
  logic [4:0]  cursor_row_copy;
  logic [7:0]  attr_copy;

  console_rsp_t  expected_answers [$];
  directed_row_t dir_rows [$];

  int error_count  = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int scroll_count = 0;
  int clear_count  = 0;
  int slow_left    = SLOW_BUDGET;
  int idle_mode    = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    error_count++;
    $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  // cursor to the start of the next row, scrolling when it passes the bottom
  function automatic void advance_line();
    cursor_col_copy = '0;
    if (cursor_row_copy == SCREEN_ROWS - 1) begin
      for (int i = 0; i < CELL_TOTAL; i++)
        screen_copy[i] = (i + SCREEN_COLS < CELL_TOTAL) ? screen_copy[i + SCREEN_COLS]
                                                          : tmcw_pkg::BLANK_BOTTOM;
      scroll_count++;
    end else begin
      cursor_row_copy++;
    end
  endfunction

  function automatic console_rsp_t predict_console(console_cmd_t it);
    console_rsp_t res;
    logic [6:0]   c;
    logic [4:0]   r;
    res = '0;
    c = (it.column > SCREEN_COLS - 1) ? 7'(SCREEN_COLS - 1) : it.column;
    r = (it.row > SCREEN_ROWS - 1) ? 5'(SCREEN_ROWS - 1) : it.row;
    case (it.command)
      tmcw_pkg::CMD_PUT: begin
        if (it.char_code == tmcw_pkg::LINE_FEED) begin
          advance_line();
        end else begin
          screen_copy[cursor_row_copy * SCREEN_COLS + cursor_col_copy] = {attr_copy, it.char_code};
          if (cursor_col_copy == SCREEN_COLS - 1)
            advance_line();
          else
            cursor_col_copy++;
        end
      end
      tmcw_pkg::CMD_READ: begin
        res.cell_entry = screen_copy[r * SCREEN_COLS + c];
      end
      tmcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELL_TOTAL; i++)
          screen_copy[i] = {attr_copy, tmcw_pkg::SPACE_CHAR};
        cursor_col_copy = '0;
        cursor_row_copy = '0;
        clear_count++;
      end
      default: begin
        cursor_col_copy = c;
        cursor_row_copy = r;
      end
    endcase
    res.cursor_column = cursor_col_copy;
    res.cursor_row    = cursor_row_copy;
    return res;
  endfunction

  // items that make the block walk the whole screen memory
  function automatic bit is_slow(console_cmd_t it);
    if (it.command == tmcw_pkg::CMD_CLEAR)
      return 1'b1;
    return it.command == tmcw_pkg::CMD_PUT && cursor_row_copy == SCREEN_ROWS - 1 &&
           (it.char_code == tmcw_pkg::LINE_FEED || cursor_col_copy == SCREEN_COLS - 1);
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == 1)
      return $urandom_range(0, 99) < 48;
    if (idle_mode == 3)
      return $urandom_range(0, 99) < 19;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == 2)
      return $urandom_range(0, 99) < 48;
    if (idle_mode == 3)
      return $urandom_range(0, 99) < 19;
    return 1'b0;
  endfunction

  function automatic console_cmd_t rand_cmd(tmcw_pkg::cmd_t c);
    console_cmd_t it;
    it.command   = c;
    it.char_code = 8'($urandom_range(0, 255));
    it.column    = 7'($urandom_range(0, 127));
    it.row       = 5'($urandom_range(0, 31));
    return it;
  endfunction

  // offer one item, then record what it should answer once accepted
  task automatic send_cmd(console_cmd_t it, bit typed, console_rsp_t answer);
    console_rsp_t predicted;
    @(negedge clk);
    while (sender_idles()) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= it.command;
    cmd_ch.char_code <= it.char_code;
    cmd_ch.column    <= it.column;
    cmd_ch.row       <= it.row;
    @(posedge clk);
    while (!cmd_ch.ready)
      @(posedge clk);
    predicted = predict_console(it);
    expected_answers.push_back(typed ? answer : predicted);
    items_sent++;
  endtask

  // keep the number of screen walks bounded so the run stays short
  task automatic issue_random(console_cmd_t it);
    if (is_slow(it)) begin
      if (slow_left == 0) begin
        it.command = tmcw_pkg::CMD_SET;
        it.row     = 5'($urandom_range(0, 12));
      end else begin
        slow_left--;
      end
    end
    send_cmd(it, 1'b0, '0);
  endtask

  task automatic add_row(tmcw_pkg::cmd_t c, logic [7:0] ch, logic [6:0] col, logic [4:0] r,
                         bit typed, logic [15:0] e, logic [6:0] ecol, logic [4:0] erow);
    directed_row_t d;
    d.item.command          = c;
    d.item.char_code        = ch;
    d.item.column           = col;
    d.item.row              = r;
    d.typed                 = typed;
    d.answer.cell_entry     = e;
    d.answer.cursor_column  = ecol;
    d.answer.cursor_row     = erow;
    dir_rows.push_back(d);
  endtask

  task automatic drain_answers();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    attr_copy = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly typed lines with random content, plus cursor moves, reads, clears and noise
  task automatic run_random_phase(int n);
    int           start;
    int           pick;
    int           burst;
    console_cmd_t it;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          it = rand_cmd(tmcw_pkg::CMD_PUT);
          if ($urandom_range(0, 15) == 0)
            it.char_code = tmcw_pkg::LINE_FEED;
          issue_random(it);
        end
        if ($urandom_range(0, 1)) begin
          it = rand_cmd(tmcw_pkg::CMD_PUT);
          it.char_code = tmcw_pkg::LINE_FEED;
          issue_random(it);
        end
      end else if (pick < 62) begin
        it = rand_cmd(tmcw_pkg::CMD_SET);
        if ($urandom_range(0, 3) == 0)
          it.column = 7'($urandom_range(SCREEN_COLS - 10, SCREEN_COLS - 1));
        if ($urandom_range(0, 9) < 7)
          it.row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        issue_random(it);
        burst = $urandom_range(0, 8);
        repeat (burst)
          issue_random(rand_cmd(tmcw_pkg::CMD_PUT));
      end else if (pick < 85) begin
        it = rand_cmd(tmcw_pkg::CMD_READ);
        if ($urandom_range(0, 1)) begin
          it.row    = cursor_row_copy;
          it.column = 7'($urandom_range(0, cursor_col_copy));
        end
        issue_random(it);
      end else if (pick < 88) begin
        issue_random(rand_cmd(tmcw_pkg::CMD_CLEAR));
      end else begin
        issue_random(rand_cmd(tmcw_pkg::cmd_t'($urandom_range(0, 3))));
      end
    end
  endtask

  // output side: random stalls, or a long hold-off when the stimulus asks for one
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !receiver_stalls();
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    console_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result with nothing expected", rsp_ch.cell_entry, '0);
      end else begin
        want = expected_answers.pop_front();
        if (rsp_ch.cell_entry !== want.cell_entry)
          report_mismatch("cell_entry", rsp_ch.cell_entry, want.cell_entry);
        if (rsp_ch.cursor_column !== want.cursor_column)
          report_mismatch("cursor_column", 16'(rsp_ch.cursor_column), 16'(want.cursor_column));
        if (rsp_ch.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", 16'(rsp_ch.cursor_row), 16'(want.cursor_row));
      end
      results_seen++;
    end
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("text_mode_console_writer_top test failed");
    $finish;
  end

  initial begin
    logic [7:0] attrs [PHASE_COUNT];
    int         modes [PHASE_COUNT];
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = tmcw_pkg::CMD_PUT;
    cmd_ch.char_code = '0;
    cmd_ch.column    = '0;
    cmd_ch.row       = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    for (int i = 0; i < CELL_TOTAL; i++)
      screen_copy[i] = tmcw_pkg::RESET_CELL;
    cursor_col_copy = '0;
    cursor_row_copy = '0;
    attr_copy       = tmcw_pkg::RESET_ATTR;
    attrs = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom), tmcw_pkg::RESET_ATTR};
    modes = '{0, 1, 2, 3, 1, 2};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows: reset contents, saturation, wrap, scroll, clear
    add_row(tmcw_pkg::CMD_READ,  8'hFF, 7'd0,   5'd0,  1'b1, tmcw_pkg::RESET_CELL, 7'd0, 5'd0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd127, 5'd31, 1'b1, tmcw_pkg::RESET_CELL, 7'd0, 5'd0);
    add_row(tmcw_pkg::CMD_PUT,   8'h41, 7'd127, 5'd31, 1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_PUT,   8'h00, 7'd0,   5'd0,  1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_PUT,   8'hFF, 7'd0,   5'd0,  1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd0,   5'd0,  1'b1, 16'h0741, 7'd3, 5'd0);
    add_row(tmcw_pkg::CMD_PUT,   tmcw_pkg::LINE_FEED, 7'd127, 5'd31, 1'b1, '0, 7'd0, 5'd1);
    add_row(tmcw_pkg::CMD_SET,   8'hFF, 7'd127, 5'd31, 1'b1, '0, 7'd79, 5'd24);
    add_row(tmcw_pkg::CMD_PUT,   8'h5A, 7'd0,   5'd0,  1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd79,  5'd23, 1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd0,   5'd24, 1'b1, tmcw_pkg::BLANK_BOTTOM, 7'd0, 5'd24);
    add_row(tmcw_pkg::CMD_SET,   8'h00, 7'd79,  5'd0,  1'b1, '0, 7'd79, 5'd0);
    add_row(tmcw_pkg::CMD_PUT,   8'h31, 7'd0,   5'd0,  1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_READ,  8'hFF, 7'd79,  5'd0,  1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_SET,   8'h00, 7'd0,   5'd24, 1'b1, '0, 7'd0, 5'd24);
    add_row(tmcw_pkg::CMD_PUT,   tmcw_pkg::LINE_FEED, 7'd0, 5'd0, 1'b0, '0, '0, '0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd79,  5'd24, 1'b1, tmcw_pkg::BLANK_BOTTOM, 7'd0, 5'd24);
    add_row(tmcw_pkg::CMD_CLEAR, 8'hFF, 7'd127, 5'd31, 1'b1, '0, 7'd0, 5'd0);
    add_row(tmcw_pkg::CMD_READ,  8'h00, 7'd40,  5'd12, 1'b1, tmcw_pkg::RESET_CELL, 7'd0, 5'd0);
    add_row(tmcw_pkg::CMD_SET,   8'h00, 7'd80,  5'd25, 1'b1, '0, 7'd79, 5'd24);
    add_row(tmcw_pkg::CMD_SET,   8'h00, 7'd0,   5'd0,  1'b1, '0, 7'd0, 5'd0);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].answer);

    // random phases, each with its own attribute and one of four idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_answers();
      write_attribute(attrs[p]);
      idle_mode <= modes[p];
      if (p == 0 || p == 3)
        hold_seq <= hold_seq + 1;
      run_random_phase(PHASE_ITEMS);
    end

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d command items and checked %0d result items", items_sent, results_seen);
    $display("covered %0d scrolls, %0d clears, six attribute values and four idling patterns",
             scroll_count, clear_count);
    if (error_count == 0 && expected_answers.size() == 0)
      $display("text_mode_console_writer_top test passed");
    else
      $display("text_mode_console_writer_top test failed");
    $finish;
  end

endmodule
